@@ hdl/cre_pkg.sv @@
// Shared types, constants and a helper function of the character range expander.
`default_nettype none

package cre_pkg;

    // ASCII dash, the range operator.
    localparam logic [7:0] DASH = 8'h2D;

    // Depth of the command queue between the front and the back end.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Character classes; only equal, nonzero classes form a range.
    localparam logic [1:0] CLASS_NONE  = 2'd0;
    localparam logic [1:0] CLASS_UPPER = 2'd1;
    localparam logic [1:0] CLASS_LOWER = 2'd2;
    localparam logic [1:0] CLASS_DIGIT = 2'd3;

    // One source character request.
    typedef struct packed {
        logic [7:0] in_char;
        logic       end_of_string;
    } cre_in_t;

    // One expanded character.
    typedef struct packed {
        logic [7:0] out_char;
        logic       string_done;
        logic       last_of_run;
    } cre_out_t;

    // Work for the back end: the run from run_first to run_last (one
    // character when they are equal), then tail_cnt further characters.
    typedef struct packed {
        logic [7:0] run_first;
        logic [7:0] run_last;
        logic [1:0] tail_cnt;
        logic [7:0] tail0;
        logic [7:0] tail1;
        logic       done;
    } cre_cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_RUN,
        BK_TAIL0,
        BK_TAIL1
    } cre_back_state_t;

    function automatic logic [1:0] char_class(input logic [7:0] c);
        logic [1:0] cl;
        case (c) inside
            [8'h41:8'h5A]: cl = CLASS_UPPER;
            [8'h61:8'h7A]: cl = CLASS_LOWER;
            [8'h30:8'h39]: cl = CLASS_DIGIT;
            default:       cl = CLASS_NONE;
        endcase
        return cl;
    endfunction

endpackage

`default_nettype wire

@@ hdl/cre_front.sv @@
// Front end: accepts source characters, tracks lookahead state and issues commands.
`default_nettype none

module cre_front (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire cre_pkg::cre_in_t s_payload,
    input  wire logic            q_full,
    output logic                 q_push,
    output cre_pkg::cre_cmd_t    q_cmd
);

    logic [7:0] left_char_reg, left_char_next;
    logic [7:0] held_char_reg, held_char_next;
    logic       held_valid_reg, held_valid_next;
    logic       dash_pending_reg, dash_pending_next;
    logic       at_start_reg, at_start_next;

    logic       accept;
    logic [7:0] x;
    logic       e;
    logic [1:0] cl_left;
    logic [1:0] cl_x;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign x       = s_payload.in_char;
    assign e       = s_payload.end_of_string;
    assign cl_left = cre_pkg::char_class(left_char_reg);
    assign cl_x    = cre_pkg::char_class(x);

    always_comb begin
        logic push;
        cre_pkg::cre_cmd_t cmd;

        left_char_next    = left_char_reg;
        held_char_next    = held_char_reg;
        held_valid_next   = held_valid_reg;
        dash_pending_next = dash_pending_reg;
        at_start_next     = at_start_reg;
        push              = 1'b0;
        cmd.run_first     = x;
        cmd.run_last      = x;
        cmd.tail_cnt      = 2'd0;
        cmd.tail0         = cre_pkg::DASH;
        cmd.tail1         = x;
        cmd.done          = e;

        if (dash_pending_reg) begin
            dash_pending_next = 1'b0;
            push              = 1'b1;
            if (cl_left != cre_pkg::CLASS_NONE && cl_left == cl_x) begin
                cmd.run_first  = left_char_reg;
                cmd.run_last   = x;
                left_char_next = x;
                at_start_next  = 1'b0;
            end else begin
                // No range: the left character and the dash go out as they are.
                cmd.run_first  = left_char_reg;
                cmd.run_last   = left_char_reg;
                cmd.tail_cnt   = 2'd1;
                cmd.tail0      = cre_pkg::DASH;
                left_char_next = cre_pkg::DASH;
                if (x == cre_pkg::DASH) begin
                    if (at_start_reg || e) begin
                        cmd.tail_cnt   = 2'd2;
                        cmd.tail1      = cre_pkg::DASH;
                    end else begin
                        dash_pending_next = 1'b1;
                    end
                end else if (e) begin
                    cmd.tail_cnt   = 2'd2;
                    cmd.tail1      = x;
                    left_char_next = x;
                end else begin
                    held_char_next  = x;
                    held_valid_next = 1'b1;
                end
                at_start_next = 1'b0;
            end
        end else if (held_valid_reg) begin
            held_valid_next = 1'b0;
            held_char_next  = 8'd0;
            left_char_next  = held_char_reg;
            if (x == cre_pkg::DASH && !e) begin
                dash_pending_next = 1'b1;
            end else begin
                push          = 1'b1;
                cmd.run_first = held_char_reg;
                cmd.run_last  = held_char_reg;
                if (x == cre_pkg::DASH) begin
                    // Trailing dash after a held character.
                    cmd.tail_cnt   = 2'd1;
                    cmd.tail0      = cre_pkg::DASH;
                    left_char_next = cre_pkg::DASH;
                end else if (e) begin
                    cmd.tail_cnt   = 2'd1;
                    cmd.tail0      = x;
                    left_char_next = x;
                end else begin
                    held_char_next  = x;
                    held_valid_next = 1'b1;
                end
                at_start_next = 1'b0;
            end
        end else begin
            if (x == cre_pkg::DASH) begin
                if (at_start_reg || e) begin
                    push           = 1'b1;
                    left_char_next = cre_pkg::DASH;
                end else begin
                    dash_pending_next = 1'b1;
                end
            end else if (e) begin
                push           = 1'b1;
                left_char_next = x;
            end else begin
                held_char_next  = x;
                held_valid_next = 1'b1;
            end
            at_start_next = 1'b0;
        end

        // The end of a string returns everything to its reset value.
        if (e) begin
            left_char_next    = 8'd0;
            held_char_next    = 8'd0;
            held_valid_next   = 1'b0;
            dash_pending_next = 1'b0;
            at_start_next     = 1'b1;
        end

        q_push = accept && push;
        q_cmd  = cmd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_char_reg    <= 8'd0;
            held_char_reg    <= 8'd0;
            held_valid_reg   <= 1'b0;
            dash_pending_reg <= 1'b0;
            at_start_reg     <= 1'b1;
        end else if (accept) begin
            left_char_reg    <= left_char_next;
            held_char_reg    <= held_char_next;
            held_valid_reg   <= held_valid_next;
            dash_pending_reg <= dash_pending_next;
            at_start_reg     <= at_start_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/cre_queue.sv @@
// Small register queue of commands between the front and the back end.
`default_nettype none

module cre_queue (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire cre_pkg::cre_cmd_t push_cmd,
    output logic                   full,
    input  wire logic              pop,
    output logic                   head_valid,
    output cre_pkg::cre_cmd_t      head_cmd
);

    cre_pkg::cre_cmd_t entry_reg [cre_pkg::QUEUE_DEPTH];

    logic [cre_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [cre_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [cre_pkg::QUEUE_CNT_W-1:0] count_reg, count_next;

    localparam logic [cre_pkg::QUEUE_PTR_W-1:0] LAST_PTR =
        cre_pkg::QUEUE_PTR_W'(cre_pkg::QUEUE_DEPTH - 1);
    localparam logic [cre_pkg::QUEUE_CNT_W-1:0] FULL_COUNT =
        cre_pkg::QUEUE_CNT_W'(cre_pkg::QUEUE_DEPTH);

    assign full       = (count_reg == FULL_COUNT);
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

@@ hdl/cre_back.sv @@
// Back end: unless stalled, walks each command a character a cycle into out_reg.
`default_nettype none

module cre_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              head_valid,
    input  wire cre_pkg::cre_cmd_t head_cmd,
    output logic                   pop,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output cre_pkg::cre_out_t      m_payload
);

    cre_pkg::cre_back_state_t state_reg, state_next;
    cre_pkg::cre_cmd_t        cmd_reg, cmd_next;
    logic [7:0]               cur_reg, cur_next;
    logic                     m_valid_reg, m_valid_next;
    cre_pkg::cre_out_t        out_reg, out_next;

    always_comb begin
        cre_pkg::cre_cmd_t        src;
        cre_pkg::cre_back_state_t after;
        logic [7:0]               ch;
        logic [7:0]               stepped;
        logic                     final_char;
        logic                     descend;
        logic                     slot_free;
        logic                     fire;

        src        = (state_reg == cre_pkg::BK_IDLE) ? head_cmd : cmd_reg;
        descend    = (src.run_last < src.run_first);
        ch         = cur_reg;
        stepped    = cur_reg;
        final_char = 1'b0;
        after      = cre_pkg::BK_IDLE;

        case (state_reg)
            cre_pkg::BK_IDLE, cre_pkg::BK_RUN: begin
                ch      = (state_reg == cre_pkg::BK_IDLE) ? src.run_first : cur_reg;
                stepped = descend ? ch - 8'd1 : ch + 8'd1;
                if (ch == src.run_last) begin
                    if (src.tail_cnt == 2'd0) begin
                        final_char = 1'b1;
                        after      = cre_pkg::BK_IDLE;
                    end else begin
                        after = cre_pkg::BK_TAIL0;
                    end
                end else begin
                    after = cre_pkg::BK_RUN;
                end
            end
            cre_pkg::BK_TAIL0: begin
                ch = src.tail0;
                if (src.tail_cnt == 2'd1) begin
                    final_char = 1'b1;
                    after      = cre_pkg::BK_IDLE;
                end else begin
                    after = cre_pkg::BK_TAIL1;
                end
            end
            cre_pkg::BK_TAIL1: begin
                ch         = src.tail1;
                final_char = 1'b1;
                after      = cre_pkg::BK_IDLE;
            end
            default: begin
                final_char = 1'b1;
                after      = cre_pkg::BK_IDLE;
            end
        endcase

        slot_free = !m_valid_reg || m_ready;
        fire      = slot_free && ((state_reg != cre_pkg::BK_IDLE) || head_valid);
        pop       = fire && (state_reg == cre_pkg::BK_IDLE);

        state_next   = state_reg;
        cmd_next     = cmd_reg;
        cur_next     = cur_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (fire) begin
            state_next           = after;
            cmd_next             = src;
            cur_next             = stepped;
            out_next.out_char    = ch;
            out_next.string_done = final_char && src.done;
            out_next.last_of_run = final_char;
            m_valid_next         = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= cre_pkg::BK_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg <= cmd_next;
        cur_reg <= cur_next;
        out_reg <= out_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = out_reg;

endmodule

`default_nettype wire

@@ hdl/character_range_expander.sv @@
// Top level of the character range expander: front end, command queue, back end.
// A character is registered into the output register when the back end takes its
// command; plain characters wait for one character of lookahead.
// Throughput: one output character per cycle unless m_ready stalls; a request
// of N characters holds the back end through all N while the queue absorbs input.
// Reset: aresetn is synchronous and active low; it empties the queue and
// returns the lookahead state to the start of a string.
`default_nettype none

module character_range_expander (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire cre_pkg::cre_in_t  s_payload,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output cre_pkg::cre_out_t      m_payload
);

    // The front end decides, at the moment a request is accepted, what the
    // request produces: a run of characters (a single character when both
    // ends are equal) followed by up to two literal characters. It holds the
    // one or two characters of lookahead that range detection needs.
    logic              q_push;
    logic              q_full;
    logic              q_pop;
    logic              q_head_valid;
    cre_pkg::cre_cmd_t q_push_cmd;
    cre_pkg::cre_cmd_t q_head_cmd;

    cre_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (q_push_cmd)
    );

    // The queue lets the front end keep taking requests while the back end
    // spells out a long range, and lets the back end run on while input stalls.
    cre_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (q_push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_cmd   (q_head_cmd)
    );

    // Unless stalled, the back end emits one character per cycle into a registered
    // output, marking the final character of each command and of each string.
    cre_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (q_head_valid),
        .head_cmd   (q_head_cmd),
        .pop        (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_payload  (m_payload)
    );

endmodule

`default_nettype wire

@@ dv/cre_expansion_checker.sv @@
// Checker for the character range expander: predicts the expanded stream and compares it.
`timescale 1ns / 100ps

module cre_expansion_checker (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    input  wire logic              s_ready,
    input  wire cre_pkg::cre_in_t  s_payload,
    input  wire logic              m_valid,
    input  wire logic              m_ready,
    input  wire cre_pkg::cre_out_t m_payload,
    output int                     fail_count,
    output int                     pending_count
);

    // Predictor state of the lookahead front end.
    logic [7:0] prev_char;
    logic [7:0] lookahead_char;
    logic       lookahead_full;
    logic       dash_waiting;
    logic       fresh_string;

    cre_pkg::cre_out_t expected_chars[$];
    cre_pkg::cre_out_t run_chars[$];
    int                failures = 0;
    int                result_index = 0;

    initial begin
        fail_count    = 0;
        pending_count = 0;
    end

    function automatic logic [1:0] class_of(input logic [7:0] c);
        if (c >= "A" && c <= "Z") return cre_pkg::CLASS_UPPER;
        if (c >= "a" && c <= "z") return cre_pkg::CLASS_LOWER;
        if (c >= "0" && c <= "9") return cre_pkg::CLASS_DIGIT;
        return cre_pkg::CLASS_NONE;
    endfunction

    task automatic clear_state();
        prev_char      = 8'h00;
        lookahead_char = 8'h00;
        lookahead_full = 1'b0;
        dash_waiting   = 1'b0;
        fresh_string   = 1'b1;
    endtask

    task automatic push_char(input logic [7:0] c, input logic done);
        cre_pkg::cre_out_t r;
        r.out_char    = c;
        r.string_done = done;
        r.last_of_run = 1'b0;
        run_chars.push_back(r);
    endtask

    // A character that nothing is waiting on: a dash may open a range, the end of a string
    // goes out, anything else is held back for one character of lookahead.
    task automatic take_fresh(input logic [7:0] x, input logic e);
        if (x == cre_pkg::DASH) begin
            if (fresh_string || e) begin
                push_char(cre_pkg::DASH, e);
                prev_char = cre_pkg::DASH;
            end else begin
                dash_waiting = 1'b1;
            end
        end else if (e) begin
            push_char(x, 1'b1);
            prev_char = x;
        end else begin
            lookahead_char = x;
            lookahead_full = 1'b1;
        end
        fresh_string = 1'b0;
    endtask

    task automatic predict_expansion(input cre_pkg::cre_in_t req);
        logic [7:0]        walk;
        logic [7:0]        held;
        cre_pkg::cre_out_t last;
        run_chars.delete();
        if (dash_waiting) begin
            dash_waiting = 1'b0;
            if (class_of(prev_char) != cre_pkg::CLASS_NONE &&
                class_of(prev_char) == class_of(req.in_char)) begin
                walk = prev_char;
                while (walk != req.in_char) begin
                    push_char(walk, 1'b0);
                    walk = (req.in_char > walk) ? walk + 8'd1 : walk - 8'd1;
                end
                push_char(req.in_char, req.end_of_string);
                prev_char    = req.in_char;
                fresh_string = 1'b0;
            end else begin
                push_char(prev_char, 1'b0);
                push_char(cre_pkg::DASH, 1'b0);
                prev_char = cre_pkg::DASH;
                take_fresh(req.in_char, req.end_of_string);
            end
        end else if (lookahead_full) begin
            held           = lookahead_char;
            lookahead_full = 1'b0;
            lookahead_char = 8'h00;
            prev_char      = held;
            if (req.in_char == cre_pkg::DASH && !req.end_of_string) begin
                dash_waiting = 1'b1;
            end else begin
                push_char(held, 1'b0);
                take_fresh(req.in_char, req.end_of_string);
            end
        end else begin
            take_fresh(req.in_char, req.end_of_string);
        end
        if (req.end_of_string) clear_state();
        if (run_chars.size() > 0) begin
            last = run_chars.pop_back();
            last.last_of_run = 1'b1;
            run_chars.push_back(last);
        end
        foreach (run_chars[i]) expected_chars.push_back(run_chars[i]);
    endtask

    task automatic check_result(input cre_pkg::cre_out_t got);
        cre_pkg::cre_out_t want;
        if (expected_chars.size() == 0) begin
            if (failures < 10)
                $display("result %0d: unexpected char %02h done %b last %b", result_index,
                         got.out_char, got.string_done, got.last_of_run);
            failures++;
        end else begin
            want = expected_chars.pop_front();
            if (got.out_char !== want.out_char || got.string_done !== want.string_done ||
                got.last_of_run !== want.last_of_run) begin
                if (failures < 10)
                    $display("result %0d: expected char %02h done %b last %b, got %02h %b %b",
                             result_index, want.out_char, want.string_done, want.last_of_run,
                             got.out_char, got.string_done, got.last_of_run);
                failures++;
            end
        end
        result_index++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_state();
            expected_chars.delete();
        end else begin
            if (m_valid && m_ready) check_result(m_payload);
            if (s_valid && s_ready) predict_expansion(s_payload);
        end
        fail_count    <= failures;
        pending_count <= expected_chars.size();
    end

endmodule

@@ dv/character_range_expander_tb.sv @@
// Testbench top of the character range expander: stimulus, sink stalls and verdict.
`timescale 1ns / 100ps

module character_range_expander_tb;

    // Roughly this many random requests follow the directed strings.
    localparam int RANDOM_ITEMS = 96;
    // The slowest correct run is well under this: every request expanding to
    // a full alphabet behind the longest sink stalls stays far below it.
    localparam int CYCLE_LIMIT  = 400000;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_valid   = 1'b0;
    cre_pkg::cre_in_t  s_payload = '0;
    logic              m_ready   = 1'b0;
    logic              s_ready;
    logic              m_valid;
    cre_pkg::cre_out_t m_payload;

    int   fail_count;
    int   pending_count;
    int   cycle_count = 0;
    int   sent_count  = 0;
    int   sink_hold   = 0;
    logic quiet_phase = 1'b0;

    // Characters of the next string, sent in order with the last one
    // marked as the end of the string.
    logic [7:0] text_q[$];

    character_range_expander u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    cre_expansion_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_payload     (s_payload),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_payload     (m_payload),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // The watchdog ends a run that hangs, for instance on a lost result.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("character_range_expander: mismatch");
            $finish;
        end
    end

    // The result side alternates between stretches of readiness and stall bursts.
    // In the quiet phase it stays ready, so the block is also seen running at
    // full rate.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            sink_hold <= 0;
        end else if (sink_hold != 0) begin
            sink_hold <= sink_hold - 1;
        end else if (!quiet_phase && $urandom_range(0, 2) == 0) begin
            m_ready   <= 1'b0;
            sink_hold <= $urandom_range(0, 9);
        end else begin
            m_ready   <= 1'b1;
            sink_hold <= $urandom_range(0, 19);
        end
    end

    // Offers one request and returns at the edge that accepts it. An idle
    // burst may come first; otherwise valid stays high into the next
    // request with only the payload changing.
    task automatic send_request(input logic [7:0] ch, input logic eos);
        if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_valid                 <= 1'b1;
        s_payload.in_char       <= ch;
        s_payload.end_of_string <= eos;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_text_q();
        foreach (text_q[i]) begin
            send_request(text_q[i], i == text_q.size() - 1);
            sent_count++;
        end
        text_q.delete();
    endtask

    task automatic send_literal(input string s);
        for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
        send_text_q();
    endtask

    function automatic logic [7:0] pick_in_class(input logic [1:0] cls);
        case (cls)
            cre_pkg::CLASS_UPPER: return 8'("A" + $urandom_range(0, 25));
            cre_pkg::CLASS_LOWER: return 8'("a" + $urandom_range(0, 25));
            cre_pkg::CLASS_DIGIT: return 8'("0" + $urandom_range(0, 9));
            default:              return 8'($urandom_range(1, 255));
        endcase
    endfunction

    // Most segments are well-formed ranges, some chained through their right
    // endpoint; the rest are class mismatches, stray dashes, plain
    // characters and arbitrary bytes.
    task automatic send_random_string();
        int         segments;
        int         kind;
        logic [1:0] cls;
        logic [1:0] other;
        segments = $urandom_range(1, 4);
        repeat (segments) begin
            kind  = $urandom_range(0, 9);
            cls   = 2'($urandom_range(1, 3));
            other = (cls == cre_pkg::CLASS_DIGIT) ? cre_pkg::CLASS_UPPER : cls + 2'd1;
            if (kind < 6) begin
                text_q.push_back(pick_in_class(cls));
                text_q.push_back(cre_pkg::DASH);
                text_q.push_back(pick_in_class(cls));
                if (kind == 5) begin
                    text_q.push_back(cre_pkg::DASH);
                    text_q.push_back(pick_in_class(cls));
                end
            end else if (kind == 6) begin
                text_q.push_back(pick_in_class(cls));
                text_q.push_back(cre_pkg::DASH);
                text_q.push_back(pick_in_class(other));
            end else if (kind == 7) begin
                text_q.push_back(cre_pkg::DASH);
            end else if (kind == 8) begin
                text_q.push_back(8'($urandom_range(1, 255)));
            end else begin
                text_q.push_back(pick_in_class(cls));
            end
        end
        send_text_q();
    endtask

    initial begin
        int directed_count;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed strings. A leading dash followed by the widest run, a
        // chain whose right endpoint opens another range, a descending digit
        // run ending in a dash, a class mismatch, a dash right after a dash,
        // equal endpoints, and the lowest nonzero and the highest byte as plain text.
        send_literal("-A-Z");
        send_literal("a-c-a");
        send_literal("9-0-");
        send_literal("a-Z");
        send_literal("--x");
        send_literal("k-k");
        text_q.push_back(8'h01);
        text_q.push_back(8'hFF);
        send_text_q();
        directed_count = sent_count;

        // Random strings; the last stretch runs with no idling at all.
        while (sent_count < directed_count + RANDOM_ITEMS) begin
            if (sent_count > directed_count + RANDOM_ITEMS * 4 / 5)
                quiet_phase <= 1'b1;
            send_random_string();
        end
        s_valid <= 1'b0;

        // Let the checker count the last request before looking at what is
        // still outstanding, then drain and allow a few trailing cycles.
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);

        if (fail_count == 0 && pending_count == 0) begin
            $display("character_range_expander: match");
        end else begin
            $display("character_range_expander: mismatch");
        end
        $finish;
    end

endmodule
